// File: rtl/core/bs3_pkg.sv
// Shared constants, types and register codes of the 3x3 box smoothing filter.
package bs3_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 512;
  localparam int unsigned DEF_MAX_HEIGHT = 256;

  localparam int unsigned PIX_W        = 8;
  localparam int unsigned WIDTH_REG_W  = 10;
  localparam int unsigned HEIGHT_REG_W = 9;
  localparam int unsigned CFG_DATA_W   = 10;

  localparam logic [PIX_W-1:0] BACKGROUND = 8'd255;

  // Nine pixels sum to at most 2295, which fits in 12 bits.
  localparam int unsigned SUM_W = 12;
  // floor(sum / 9) == (sum * 3641) >> 15 for every sum below 3641.
  localparam logic [SUM_W-1:0] DIV9_MUL   = 12'd3641;
  localparam int unsigned      DIV9_SHIFT = 15;
  localparam int unsigned      PROD_W     = 2 * SUM_W;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } bs3_reg_e;

  // Per-item control that travels with a pixel through the pipeline.
  typedef struct packed {
    logic emit;      // this item releases one output pixel
    logic last;      // the released pixel is the last one of the frame
    logic top_ok;    // row above the output pixel lies inside the frame
    logic bot_ok;    // row below the output pixel lies inside the frame
    logic left_ok;   // column left of the output pixel lies inside the frame
    logic right_ok;  // column right of the output pixel lies inside the frame
  } bs3_tag_t;

  // One new window column: two rows from the line buffers and the new pixel.
  typedef struct packed {
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] cur;
  } bs3_col_t;

  // Nine masked neighbourhood values, row-major.
  typedef logic [8:0][PIX_W-1:0] bs3_taps_t;

endpackage

// File: rtl/core/bs3_pix_if.sv
// Input pixel channel: valid/ready handshake with mode and pixel payload.
interface bs3_pix_if;
  import bs3_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output mode, output pixel, input ready);
  modport sink   (input valid, input mode, input pixel, output ready);

endinterface

// File: rtl/core/bs3_res_if.sv
// Result channel: valid/ready handshake with smoothed pixel and frame end flag.
interface bs3_res_if;
  import bs3_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] smoothed;
  logic             frame_end;

  modport source (output valid, output smoothed, output frame_end, input ready);
  modport sink   (input valid, input smoothed, input frame_end, output ready);

endinterface

// File: rtl/core/bs3_ctrl.sv
// Frame size registers and raster position counters of the smoothing filter.
module bs3_ctrl #(
  parameter int unsigned MAX_WIDTH  = bs3_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bs3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  bs3_pkg::bs3_reg_e                   cfg_idx_i,
  input  logic [bs3_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                mode_i,
  input  logic [bs3_pkg::PIX_W-1:0]           pixel_i,
  output logic                                load_o,
  output logic [$clog2(MAX_WIDTH)-1:0]        addr_o,
  output logic [bs3_pkg::PIX_W-1:0]           pix_o,
  output bs3_pkg::bs3_tag_t                   tag_o,
  output logic                                restart_o
);
  import bs3_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W = COL_W + 1;
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT) + 1;

  localparam logic [WID_W-1:0] RST_WIDTH  = WID_W'((MAX_WIDTH < 64) ? MAX_WIDTH : 64);
  localparam logic [ROW_W-1:0] RST_HEIGHT = ROW_W'((MAX_HEIGHT < 64) ? MAX_HEIGHT : 64);

  logic [WID_W-1:0] width_q, width_d;
  logic [ROW_W-1:0] height_q, height_d;
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic [COL_W-1:0] out_col_q, out_col_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;

  logic [31:0]      wr_w;
  logic [31:0]      wr_h;
  logic [WID_W-1:0] width_clamp;
  logic [ROW_W-1:0] height_clamp;

  logic accept, full, ignore, step, emit, last;
  logic col_last, out_col_last, out_row_last;

  // Out-of-range sizes are clamped to 1..MAX.
  always_comb begin
    wr_w = 32'(cfg_data_i[WIDTH_REG_W-1:0]);
    wr_h = 32'(cfg_data_i[HEIGHT_REG_W-1:0]);
    if (wr_w == 32'd0) begin
      width_clamp = WID_W'(1);
    end else if (wr_w > 32'(MAX_WIDTH)) begin
      width_clamp = WID_W'(MAX_WIDTH);
    end else begin
      width_clamp = wr_w[WID_W-1:0];
    end
    if (wr_h == 32'd0) begin
      height_clamp = ROW_W'(1);
    end else if (wr_h > 32'(MAX_HEIGHT)) begin
      height_clamp = ROW_W'(MAX_HEIGHT);
    end else begin
      height_clamp = wr_h[ROW_W-1:0];
    end
  end

  assign accept       = in_valid_i && in_ready_i;
  assign full         = (in_row_q >= height_q);
  assign ignore       = mode_i && !full;
  assign step         = accept && !ignore;
  assign col_last     = (({1'b0, in_col_q} + WID_W'(1)) == width_q);
  assign out_col_last = (({1'b0, out_col_q} + WID_W'(1)) == width_q);
  assign out_row_last = ((out_row_q + ROW_W'(1)) == height_q);
  // The first width+1 items of a frame release nothing.
  assign emit         = !((in_row_q == '0) || ((in_row_q == ROW_W'(1)) && (in_col_q == '0)));
  assign last         = emit && out_col_last && out_row_last;

  assign load_o    = step;
  assign addr_o    = in_col_q;
  assign pix_o     = (mode_i || full) ? BACKGROUND : pixel_i;
  assign restart_o = cfg_we_i;

  always_comb begin
    tag_o.emit     = emit;
    tag_o.last     = last;
    tag_o.top_ok   = (out_row_q != '0);
    tag_o.bot_ok   = !out_row_last;
    tag_o.left_ok  = (out_col_q != '0);
    tag_o.right_ok = !out_col_last;
  end

  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  width_d  = width_clamp;
        REG_FRAME_HEIGHT: height_d = height_clamp;
        default: ;
      endcase
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (step) begin
      if (last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else begin
        if (col_last) begin
          in_col_d = '0;
          in_row_d = in_row_q + ROW_W'(1);
        end else begin
          in_col_d = in_col_q + COL_W'(1);
        end
        if (emit) begin
          if (out_col_last) begin
            out_col_d = '0;
            out_row_d = out_row_q + ROW_W'(1);
          end else begin
            out_col_d = out_col_q + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= RST_WIDTH;
      height_q  <= RST_HEIGHT;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

// File: rtl/core/bs3_line_buf.sv
// Two line buffers in one memory, with the input stage register and write bypass.
module bs3_line_buf #(
  parameter int unsigned MAX_WIDTH = bs3_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr_i,
  input  logic [bs3_pkg::PIX_W-1:0]    pix_i,
  input  bs3_pkg::bs3_tag_t            tag_i,
  input  logic                         fire_i,
  output logic                         ready_o,
  output logic                         valid_o,
  output bs3_pkg::bs3_col_t            col_o,
  output bs3_pkg::bs3_tag_t            tag_o
);
  import bs3_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ENT_W = 2 * PIX_W;

  // Each entry holds {upper line, middle line} of one column.
  logic [ENT_W-1:0] line_mem [MAX_WIDTH];

  logic             valid_q, valid_d;
  logic [COL_W-1:0] addr_q;
  logic [PIX_W-1:0] pix_q;
  bs3_tag_t         tag_q;
  logic [ENT_W-1:0] rd_q;
  logic             byp_q;
  logic [ENT_W-1:0] byp_data_q;

  logic [ENT_W-1:0] rd_eff;
  logic [ENT_W-1:0] wr_data;
  logic             wr_en;

  // A write leaving the stage in the same cycle as a read of the same column
  // (one-pixel rows) is forwarded, since the read sees the old entry.
  assign rd_eff  = byp_q ? byp_data_q : rd_q;
  assign wr_data = {rd_eff[PIX_W-1:0], pix_q};
  assign wr_en   = valid_q && fire_i;

  assign ready_o = !valid_q || fire_i;
  assign valid_o = valid_q;
  assign tag_o   = tag_q;

  always_comb begin
    col_o.up  = rd_eff[ENT_W-1:PIX_W];
    col_o.mid = rd_eff[PIX_W-1:0];
    col_o.cur = pix_q;
  end

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (fire_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[addr_q] <= wr_data;
    end
    if (load_i) begin
      rd_q <= line_mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      addr_q     <= addr_i;
      pix_q      <= pix_i;
      tag_q      <= tag_i;
      byp_q      <= wr_en && (addr_q == addr_i);
      byp_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule

// File: rtl/core/bs3_window.sv
// 3x3 window registers and the stage that holds the masked neighbourhood.
module bs3_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               restart_i,
  input  logic               fire_i,
  input  bs3_pkg::bs3_col_t  col_i,
  input  bs3_pkg::bs3_tag_t  tag_i,
  input  logic               next_ready_i,
  output logic               ready_o,
  output logic               valid_o,
  output bs3_pkg::bs3_taps_t taps_o,
  output logic               last_o
);
  import bs3_pkg::*;

  logic [PIX_W-1:0] win_q [3][3];
  logic [PIX_W-1:0] win_d [3][3];
  logic [PIX_W-1:0] win_sh [3][3];
  logic [2:0]       row_ok;
  logic [2:0]       col_ok;
  bs3_taps_t        taps_d;
  bs3_taps_t        taps_q;
  logic             last_q;
  logic             valid_q, valid_d;
  logic             take;

  assign row_ok = {tag_i.bot_ok, 1'b1, tag_i.top_ok};
  assign col_ok = {tag_i.right_ok, 1'b1, tag_i.left_ok};
  assign take   = fire_i && tag_i.emit;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_sh[i][0] = win_q[i][1];
      win_sh[i][1] = win_q[i][2];
    end
    win_sh[0][2] = col_i.up;
    win_sh[1][2] = col_i.mid;
    win_sh[2][2] = col_i.cur;

    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        taps_d[i*3+j] = (row_ok[i] && col_ok[j]) ? win_sh[i][j] : BACKGROUND;
      end
    end

    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (restart_i || (fire_i && tag_i.last)) begin
          win_d[i][j] = BACKGROUND;
        end else if (fire_i) begin
          win_d[i][j] = win_sh[i][j];
        end else begin
          win_d[i][j] = win_q[i][j];
        end
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (next_ready_i) begin
      valid_d = 1'b0;
    end
  end

  assign ready_o = !valid_q || next_ready_i;
  assign valid_o = valid_q;
  assign taps_o  = taps_q;
  assign last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= BACKGROUND;
        end
      end
      valid_q <= 1'b0;
    end else begin
      win_q   <= win_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      taps_q <= taps_d;
      last_q <= tag_i.last;
    end
  end

endmodule

// File: rtl/core/bs3_mean.sv
// Sum stage and divide-by-nine output register of the smoothing filter.
module bs3_mean (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  bs3_pkg::bs3_taps_t        taps_i,
  input  logic                      last_i,
  output logic                      ready_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [bs3_pkg::PIX_W-1:0] smoothed_o,
  output logic                      frame_end_o
);
  import bs3_pkg::*;

  logic [SUM_W-1:0]  sum_d;
  logic [SUM_W-1:0]  sum_q;
  logic              sum_last_q;
  logic              sum_valid_q, sum_valid_d;
  logic [PROD_W-1:0] prod;
  logic              out_valid_q, out_valid_d;
  logic [PIX_W-1:0]  smoothed_q;
  logic              frame_end_q;
  logic              out_adv;
  logic              sum_load;

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < 9; k++) begin
      sum_d = sum_d + SUM_W'(taps_i[k]);
    end
  end

  assign prod     = PROD_W'(sum_q) * PROD_W'(DIV9_MUL);
  assign out_adv  = !out_valid_q || out_ready_i;
  assign sum_load = !sum_valid_q || out_adv;
  assign ready_o  = sum_load;

  always_comb begin
    sum_valid_d = sum_valid_q;
    if (valid_i && sum_load) begin
      sum_valid_d = 1'b1;
    end else if (out_adv) begin
      sum_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (sum_valid_q && out_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_valid_q <= sum_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && sum_load) begin
      sum_q      <= sum_d;
      sum_last_q <= last_i;
    end
    if (sum_valid_q && out_adv) begin
      smoothed_q  <= prod[DIV9_SHIFT +: PIX_W];
      frame_end_q <= sum_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign smoothed_o  = smoothed_q;
  assign frame_end_o = frame_end_q;

endmodule

// File: rtl/core/box_smooth_3x3.sv
// Top level of the streaming 3x3 box smoothing filter over raster-order frames.
// Throughput: one transfer per clock on each side; the input stalls only when
// the result side holds back ready and every stage is full.
// Path: an item that releases a result passes through the line read, window,
// sum and output registers in that order, and can wait in any of them.
// Reset: asynchronous, active low; 64 x 64 frame, counters zero, window background.
module box_smooth_3x3 #(
  parameter int unsigned MAX_WIDTH  = bs3_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bs3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  bs3_pkg::bs3_reg_e              cfg_idx_i,
  input  logic [bs3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bs3_pix_if.sink                        src_i,
  bs3_res_if.source                      res_o
);
  import bs3_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  // Control stage outputs, valid in the cycle of an input transfer.
  logic             load;
  logic [COL_W-1:0] addr;
  logic [PIX_W-1:0] pix;
  bs3_tag_t         tag_in;
  logic             restart;

  // Line read stage.
  logic     lb_ready;
  logic     lb_valid;
  bs3_col_t lb_col;
  bs3_tag_t lb_tag;
  logic     lb_fire;

  // Masked window stage.
  logic      win_ready;
  logic      win_valid;
  bs3_taps_t win_taps;
  logic      win_last;

  // Sum stage.
  logic sum_ready;

  // The counters decide at the transfer whether the item is a real pixel, a
  // drain item (a pixel after the frame counts as one, its value replaced by
  // background) or an early drain item that is taken and dropped. They also
  // decide whether the item releases an output and which neighbours of that
  // output fall outside the frame.
  bs3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (src_i.valid),
    .in_ready_i (lb_ready),
    .mode_i     (src_i.mode),
    .pixel_i    (src_i.pixel),
    .load_o     (load),
    .addr_o     (addr),
    .pix_o      (pix),
    .tag_o      (tag_in),
    .restart_o  (restart)
  );

  assign src_i.ready = lb_ready;

  // An item leaves the line stage when it releases no output, or when the
  // window stage can take its snapshot. Leaving updates the window and writes
  // the line buffers back.
  assign lb_fire = lb_valid && (!lb_tag.emit || win_ready);

  bs3_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .addr_i  (addr),
    .pix_i   (pix),
    .tag_i   (tag_in),
    .fire_i  (lb_fire),
    .ready_o (lb_ready),
    .valid_o (lb_valid),
    .col_o   (lb_col),
    .tag_o   (lb_tag)
  );

  // The window shifts by one column per item; the output's neighbourhood is
  // taken with out-of-frame places replaced by background. The window goes
  // back to background after the last output of a frame and on a register
  // write, so the next item starts a new frame.
  bs3_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (restart),
    .fire_i       (lb_fire),
    .col_i        (lb_col),
    .tag_i        (lb_tag),
    .next_ready_i (sum_ready),
    .ready_o      (win_ready),
    .valid_o      (win_valid),
    .taps_o       (win_taps),
    .last_o       (win_last)
  );

  // Nine-way sum, then a reciprocal multiply for the truncating divide by
  // nine into the output register.
  bs3_mean u_mean (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (win_valid),
    .taps_i      (win_taps),
    .last_i      (win_last),
    .ready_o     (sum_ready),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .smoothed_o  (res_o.smoothed),
    .frame_end_o (res_o.frame_end)
  );

endmodule

// File: dv/bs3_mean_checker.sv
// Checker of the 3x3 box smoothing filter: predicts each smoothed pixel and compares results.
module bs3_mean_checker #(
  parameter int unsigned MAX_WIDTH  = bs3_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bs3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  bs3_pkg::bs3_reg_e              cfg_idx_i,
  input  logic [bs3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bs3_pix_if                             src_i,
  bs3_res_if                             res_i,
  output int unsigned                    pending_o,
  output int unsigned                    errors_o
);
  import bs3_pkg::*;

  localparam int unsigned RESET_SIZE = 64;
  localparam int unsigned TAPS       = 9;

  typedef struct packed {
    logic [PIX_W-1:0] smoothed;
    logic             frame_end;
  } mean_t;

  mean_t expected_means[$];

  logic [PIX_W-1:0]        upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0]        middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0]        win [3][3];
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  int unsigned             col_pos;
  int unsigned             row_pos;
  int unsigned             emit_pos;
  int unsigned             results_seen;

  initial begin
    errors_o     = 0;
    pending_o    = 0;
    results_seen = 0;
  end

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic restart_frame();
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) win[i][j] = BACKGROUND;
    end
    col_pos  = 0;
    row_pos  = 0;
    emit_pos = 0;
  endtask

  task automatic report_mismatch(input string what);
    errors_o++;
    $display("%0t: box filter mismatch: %s", $time, what);
  endtask

  task automatic write_register(input bs3_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FRAME_WIDTH: begin
        width_reg = data[WIDTH_REG_W-1:0];
        restart_frame();
      end
      REG_FRAME_HEIGHT: begin
        height_reg = data[HEIGHT_REG_W-1:0];
        restart_frame();
      end
      default: ;
    endcase
  endtask

  // Shifts one item into the window model and queues the mean it releases, if any.
  task automatic predict_item(input logic drain_in, input logic [PIX_W-1:0] pix_in);
    int unsigned      w;
    int unsigned      h;
    int unsigned      total;
    int unsigned      pos;
    int unsigned      c;
    int unsigned      q;
    int unsigned      sum;
    int               cy;
    int               cx;
    int               ny;
    int               nx;
    logic             drain;
    logic [PIX_W-1:0] pix;
    mean_t            m;
    w     = clamp_dim(width_reg, MAX_WIDTH);
    h     = clamp_dim(height_reg, MAX_HEIGHT);
    total = w * h;
    pos   = row_pos * w + col_pos;
    drain = drain_in;
    pix   = pix_in;
    c     = col_pos % MAX_WIDTH;
    // A drain before the frame is complete is dropped; a pixel after it acts as a drain.
    if (pos >= total) drain = 1'b1;
    else if (drain) return;
    if (drain) pix = BACKGROUND;

    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2]     = upper_mem[c];
    win[1][2]     = middle_mem[c];
    win[2][2]     = pix;
    upper_mem[c]  = middle_mem[c];
    middle_mem[c] = pix;

    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end

    if (pos < w + 1 || emit_pos >= total) return;

    q   = emit_pos;
    cy  = int'(q / w);
    cx  = int'(q % w);
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ny = cy + i - 1;
        nx = cx + j - 1;
        if (ny >= 0 && nx >= 0 && ny < int'(h) && nx < int'(w)) sum += win[i][j];
        else sum += BACKGROUND;
      end
    end
    m.smoothed  = PIX_W'(sum / TAPS);
    m.frame_end = (q == total - 1);
    expected_means = {expected_means, m};
    emit_pos++;
    if (m.frame_end) restart_frame();
  endtask

  task automatic check_result(input logic [PIX_W-1:0] got_mean, input logic got_end);
    mean_t want;
    results_seen++;
    if (expected_means.size() == 0) begin
      report_mismatch($sformatf("result %0d (smoothed %0d, frame_end %0b) was not expected",
                                results_seen, got_mean, got_end));
      return;
    end
    want = expected_means.pop_front();
    if (got_mean !== want.smoothed)
      report_mismatch($sformatf("result %0d smoothed %0d, expected %0d",
                                results_seen, got_mean, want.smoothed));
    if (got_end !== want.frame_end)
      report_mismatch($sformatf("result %0d frame_end %0b, expected %0b",
                                results_seen, got_end, want.frame_end));
  endtask

  // Results are compared before the new input is predicted: a result never
  // belongs to the input that transfers at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_mem[i]  = '0;
        middle_mem[i] = '0;
      end
      width_reg  = WIDTH_REG_W'(RESET_SIZE);
      height_reg = HEIGHT_REG_W'(RESET_SIZE);
      restart_frame();
      expected_means.delete();
    end else begin
      if (res_i.valid && res_i.ready) check_result(res_i.smoothed, res_i.frame_end);
      if (cfg_we_i) write_register(cfg_idx_i, cfg_data_i);
      if (src_i.valid && src_i.ready) predict_item(src_i.mode, src_i.pixel);
    end
    pending_o = expected_means.size();
  end

endmodule

// File: dv/box_smooth_3x3_test.sv
// Top of the 3x3 box smoothing filter testbench: clock, reset, stimulus and verdict.
module box_smooth_3x3_test;
  import bs3_pkg::*;

  // The mode bit of an input item: a raster pixel, or a drain item that
  // flushes the outputs still held back after the frame's last pixel.
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  localparam int unsigned RESET_CYCLES  = 5;
  // Idle cycles before a register write, so that a result still in flight is never cut off.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_ITEMS   = 100;
  // Pixels sent into the widest frame before it is cut short: a little more
  // than one line, so that its first outputs come out.
  localparam int unsigned WIDE_ITEMS    = 530;
  // The watchdog ends the run when the cycle count reaches this.
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  bs3_reg_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  bs3_pix_if pix ();
  bs3_res_if res ();

  int unsigned means_pending;
  int unsigned mean_errors;

  // Idle rates in percent; the receiver process reads its own, the sender tasks the other.
  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 80;
  // The main process asks for a long receiver hold; the receiver grants it.
  int unsigned holds_asked   = 0;
  int unsigned holds_granted = 0;
  int unsigned cycle_count   = 0;
  int unsigned items_sent    = 0;
  // Effective frame size as the block sees it after clamping.
  int unsigned cur_width     = 64;
  int unsigned cur_height    = 64;
  // Set when a frame was cut short, so the next frame must restart it by a write.
  bit          frame_open    = 1'b0;

  box_smooth_3x3 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .src_i      (pix),
    .res_o      (res)
  );

  bs3_mean_checker mean_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .src_i      (pix),
    .res_i      (res),
    .pending_o  (means_pending),
    .errors_o   (mean_errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side. Ready changes only at the falling edge. A granted hold keeps
  // ready low for a long stretch so the pipeline fills and the block has to
  // push back on its input.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_granted != holds_asked) begin
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        holds_granted++;
      end else begin
        res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Pixel values lean on the two extremes so that sums at both ends of the
  // divider's range come up often.
  function automatic logic [PIX_W-1:0] pick_pixel();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return PIX_W'($urandom);
  endfunction

  // Offers one item, with random idle cycles before it, and returns at the
  // falling edge after its transfer. Valid stays high into the next item
  // unless that item idles first.
  task automatic offer_item(input logic mode, input logic [PIX_W-1:0] pixel);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.mode  <= mode;
    pix.pixel <= pixel;
    do @(posedge clk_i); while (!pix.ready);
    @(negedge clk_i);
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic wait_for_results();
    pix.valid <= 1'b0;
    @(negedge clk_i);
    while (means_pending != 0) @(negedge clk_i);
  endtask

  // Writes both size registers while the block is idle. Each write restarts
  // the frame, so a frame cut short is closed off here as well.
  task automatic set_frame_size(input logic [CFG_DATA_W-1:0] w_val,
                                input logic [CFG_DATA_W-1:0] h_val);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_FRAME_WIDTH;
    cfg_data <= w_val;
    @(negedge clk_i);
    cfg_idx  <= REG_FRAME_HEIGHT;
    cfg_data <= h_val;
    @(negedge clk_i);
    cfg_we     <= 1'b0;
    cur_width  = clamp_dim(w_val[WIDTH_REG_W-1:0], DEF_MAX_WIDTH);
    cur_height = clamp_dim(h_val[HEIGHT_REG_W-1:0], DEF_MAX_HEIGHT);
    frame_open = 1'b0;
  endtask

  // Streams one frame at the current size: its pixels, then width+1 flush
  // items. Stray drains are mixed in among the pixels (the block drops them),
  // some flush items are sent as pixels (which act as drains), and now and
  // then the sender pauses until all results are back. A broken frame stops
  // at a random point and is left for the next register write to restart.
  task automatic stream_frame(input bit may_break);
    int unsigned total;
    int unsigned length;
    int unsigned k;
    total  = cur_width * cur_height;
    length = total + cur_width + 1;
    if (may_break && $urandom_range(0, 99) < 8) begin
      length     = $urandom_range(0, length - 1);
      frame_open = 1'b1;
    end
    for (k = 0; k < length; k++) begin
      if (k < total) begin
        if ($urandom_range(0, 99) < 3) offer_item(MODE_DRAIN, pick_pixel());
        if ($urandom_range(0, 99) < 2) wait_for_results();
        offer_item(MODE_PIXEL, pick_pixel());
      end else if ($urandom_range(0, 9) == 0) begin
        offer_item(MODE_PIXEL, pick_pixel());
      end else begin
        offer_item(MODE_DRAIN, pick_pixel());
      end
      items_sent++;
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] w_val;
    logic [CFG_DATA_W-1:0] h_val;

    // Every input is known from time zero, while reset is held low.
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_FRAME_WIDTH;
    cfg_data  = '0;
    pix.valid = 1'b0;
    pix.mode  = MODE_PIXEL;
    pix.pixel = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // A 3 x 2 frame: a drain before any pixel and one in the middle are both
    // dropped, and a pixel item past the last pixel counts as a flush item.
    set_frame_size(CFG_DATA_W'(3), CFG_DATA_W'(2));
    offer_item(MODE_DRAIN, 8'hA5);
    offer_item(MODE_PIXEL, 8'h00);
    offer_item(MODE_PIXEL, 8'hFF);
    offer_item(MODE_PIXEL, 8'h80);
    offer_item(MODE_DRAIN, 8'h5A);
    offer_item(MODE_PIXEL, 8'h01);
    offer_item(MODE_PIXEL, 8'hFE);
    offer_item(MODE_PIXEL, 8'h55);
    offer_item(MODE_DRAIN, 8'h00);
    offer_item(MODE_PIXEL, 8'hAA);
    offer_item(MODE_DRAIN, 8'hFF);
    offer_item(MODE_DRAIN, 8'h00);

    // Zero sizes clamp to a single pixel. Two frames back to back check that
    // the end of a frame brings the block back to its start.
    set_frame_size('0, '0);
    offer_item(MODE_PIXEL, 8'hFF);
    offer_item(MODE_DRAIN, 8'h00);
    offer_item(MODE_DRAIN, 8'h00);
    offer_item(MODE_PIXEL, 8'h00);
    offer_item(MODE_DRAIN, 8'hFF);
    offer_item(MODE_DRAIN, 8'hFF);

    // A 2 x 2 frame left with no flush items: the next register write has to restart it.
    set_frame_size(CFG_DATA_W'(2), CFG_DATA_W'(2));
    offer_item(MODE_PIXEL, 8'h07);
    offer_item(MODE_PIXEL, 8'hC8);
    offer_item(MODE_PIXEL, 8'h21);
    offer_item(MODE_PIXEL, 8'hFF);

    // Size extremes. The width register at its top value clamps to the widest
    // line; a little more than one line goes in, so the first outputs of the
    // first row come out, and a long receiver hold once they start makes the
    // block stall its input. The frame is then cut short. The height write
    // carries a tenth data bit that the register drops.
    set_frame_size('1, CFG_DATA_W'(2));
    for (int k = 0; k < WIDE_ITEMS; k++) begin
      if (k == cur_width) holds_asked++;
      offer_item(MODE_PIXEL, pick_pixel());
    end
    frame_open = 1'b1;
    set_frame_size(CFG_DATA_W'(1), '1);
    stream_frame(1'b0);

    // Random frames in three idle settings: slow receiver, slow sender, and both
    // at full rate with one long receiver hold. Sizes are mostly small, sometimes zero
    // (clamped) or somewhat wider and taller; half the frames reuse the previous size.
    items_sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          holds_asked++;
        end
      endcase
      while (items_sent < (phase + 1) * PHASE_ITEMS) begin
        if (frame_open || $urandom_range(0, 1) == 0) begin
          if ($urandom_range(0, 99) < 5) w_val = '0;
          else if ($urandom_range(0, 9) == 0) w_val = CFG_DATA_W'($urandom_range(13, 24));
          else w_val = CFG_DATA_W'($urandom_range(1, 12));
          if ($urandom_range(0, 99) < 5) h_val = '0;
          else if ($urandom_range(0, 9) == 0) h_val = CFG_DATA_W'($urandom_range(9, 12));
          else h_val = CFG_DATA_W'($urandom_range(1, 8));
          set_frame_size(w_val, h_val);
        end
        stream_frame(1'b1);
      end
    end

    // Let every expected result arrive, then a few more cycles for any stray one.
    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mean_errors == 0 && means_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bs3_pkg.sv
rtl/core/bs3_pix_if.sv
rtl/core/bs3_res_if.sv
rtl/core/bs3_ctrl.sv
rtl/core/bs3_line_buf.sv
rtl/core/bs3_window.sv
rtl/core/bs3_mean.sv
rtl/core/box_smooth_3x3.sv
dv/bs3_mean_checker.sv
dv/box_smooth_3x3_test.sv
